// ----- src/two_level_key_histogram_defines.svh -----
// assertion macros shared by the two_level_key_histogram checkers
`ifndef TWO_LEVEL_KEY_HISTOGRAM_DEFINES_SVH
`define TWO_LEVEL_KEY_HISTOGRAM_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TKH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TKH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tkh_pkg.sv -----
// shared types, constants and helpers for the two-level key histogram
package tkh_pkg;

	localparam int TKH_MAX_TYPES    = 64;
	localparam int TKH_MAX_VERSIONS = 8;

	localparam int TKH_KEY_W  = 32;
	localparam int TKH_CNT_W  = 32;
	localparam int TKH_STAT_W = 2;
	localparam int TKH_IN_W   = 64;
	localparam int TKH_OUT_W  = 72;

	typedef enum logic [TKH_STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_TYPE_FULL = 2'd1,
		STAT_VER_FULL  = 2'd2
	} tkh_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TSCAN,
		ST_TUPD,
		ST_VSCAN,
		ST_VUPD,
		ST_DONE
	} tkh_state_t;

	typedef struct packed {
		logic load;
		logic tscan;
		logic tupd;
		logic vscan;
		logic vupd;
		logic out_load;
	} tkh_cmd_t;

	typedef struct packed {
		logic t_hit;
		logic t_miss;
		logic t_full;
		logic v_hit;
		logic v_miss;
		logic v_full;
		logic out_busy;
	} tkh_sts_t;

	function automatic logic [TKH_CNT_W-1:0] sat_inc(input logic [TKH_CNT_W-1:0] v);
		logic [TKH_CNT_W-1:0] r;
		r = (v == '1) ? v : v + TKH_CNT_W'(1);
		return r;
	endfunction

endpackage

// ----- src/tkh_ctrl.sv -----
// controller state machine sequencing the type scan, version scan and result load
module tkh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  tkh_pkg::tkh_sts_t sts,
	output tkh_pkg::tkh_cmd_t cmd
);
	import tkh_pkg::*;

	tkh_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_TSCAN;
				end
			end
			ST_TSCAN: begin
				cmd.tscan = 1'b1;
				if (sts.t_hit) begin
					state_d = ST_TUPD;
				end else if (sts.t_miss) begin
					state_d = sts.t_full ? ST_DONE : ST_TUPD;
				end
			end
			ST_TUPD: begin
				cmd.tupd = 1'b1;
				state_d  = ST_VSCAN;
			end
			ST_VSCAN: begin
				cmd.vscan = 1'b1;
				if (sts.v_hit) begin
					state_d = ST_VUPD;
				end else if (sts.v_miss) begin
					state_d = sts.v_full ? ST_DONE : ST_VUPD;
				end
			end
			ST_VUPD: begin
				cmd.vupd = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/tkh_dp.sv -----
// datapath: type and version tables, scan pointers, counters and output register
module tkh_dp #(
	parameter int MAX_TYPES    = tkh_pkg::TKH_MAX_TYPES,
	parameter int MAX_VERSIONS = tkh_pkg::TKH_MAX_VERSIONS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tkh_pkg::tkh_cmd_t              cmd,
	output tkh_pkg::tkh_sts_t              sts,
	input  logic [tkh_pkg::TKH_KEY_W-1:0]  type_code,
	input  logic [tkh_pkg::TKH_KEY_W-1:0]  version,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tkh_pkg::TKH_OUT_W-1:0]  m_tdata
);
	import tkh_pkg::*;

	localparam int IW     = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int TCW    = $clog2(MAX_TYPES + 1);
	localparam int VIW    = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
	localparam int VCW    = $clog2(MAX_VERSIONS + 1);
	localparam int VDEPTH = MAX_TYPES * MAX_VERSIONS;
	localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
	localparam int PW     = VAW + VCW;
	localparam int PAD_W  = TKH_OUT_W - (TKH_STAT_W + 2 * TKH_CNT_W + 2);

	// tables
	logic [TKH_KEY_W-1:0] type_keys_mem [MAX_TYPES];
	logic [TKH_CNT_W-1:0] type_cnt_mem  [MAX_TYPES];
	logic [VCW-1:0]       vused_mem     [MAX_TYPES];
	logic [TKH_KEY_W-1:0] ver_keys_mem  [VDEPTH];
	logic [TKH_CNT_W-1:0] ver_cnt_mem   [VDEPTH];

	logic [TKH_KEY_W-1:0] tkey_rd, vkey_rd;
	logic [TKH_CNT_W-1:0] tcnt_rd, vcnt_rd;
	logic [VCW-1:0]       vused_rd;

	// item and scan registers
	logic [TKH_KEY_W-1:0] code_q, ver_q;
	logic [TCW-1:0]       types_in_use_q;
	logic [TCW-1:0]       tptr_q;
	logic                 t_rv_q;
	logic [IW-1:0]        t_ridx_q;
	logic [IW-1:0]        ti_q;
	logic [TKH_CNT_W-1:0] tcount_q;
	logic [VCW-1:0]       nv_q;
	logic                 new_type_q;
	logic [TKH_CNT_W-1:0] tot_q;
	logic [VAW-1:0]       vbase_q;
	logic [VCW-1:0]       vptr_q;
	logic                 v_rv_q;
	logic [VIW-1:0]       v_ridx_q;
	logic [VIW-1:0]       vi_q;
	logic [TKH_CNT_W-1:0] vcount_q;
	logic                 new_ver_q;
	logic [TKH_CNT_W-1:0] vtot_q;
	tkh_stat_t            stat_q;

	// output register
	logic                 m_tvalid_q;
	tkh_stat_t            o_stat_q;
	logic [TKH_CNT_W-1:0] o_ttot_q, o_vtot_q;
	logic                 o_ntype_q, o_nver_q;

	logic [IW-1:0]        t_addr;
	logic [VAW-1:0]       v_raddr, v_waddr;
	logic                 t_issue, v_issue;
	logic [TKH_CNT_W-1:0] tc_new, vc_new;
	logic [PW-1:0]        base_prod;

	assign t_addr    = tptr_q[IW-1:0];
	assign v_raddr   = vbase_q + VAW'(vptr_q[VIW-1:0]);
	assign v_waddr   = vbase_q + VAW'(vi_q);
	assign t_issue   = tptr_q < types_in_use_q;
	assign v_issue   = vptr_q < nv_q;
	assign tc_new    = sat_inc(tcount_q);
	assign vc_new    = sat_inc(vcount_q);
	assign base_prod = PW'(ti_q) * PW'(MAX_VERSIONS);

	always_comb begin
		sts          = '0;
		sts.t_hit    = t_rv_q && (tkey_rd == code_q);
		sts.t_miss   = !t_issue && !t_rv_q;
		sts.t_full   = types_in_use_q == TCW'(MAX_TYPES);
		sts.v_hit    = v_rv_q && (vkey_rd == ver_q);
		sts.v_miss   = !v_issue && !v_rv_q;
		sts.v_full   = nv_q == VCW'(MAX_VERSIONS);
		sts.out_busy = m_tvalid_q && !m_tready;
	end

	// type table ports
	always_ff @(posedge clk) begin
		tkey_rd  <= type_keys_mem[t_addr];
		tcnt_rd  <= type_cnt_mem[t_addr];
		vused_rd <= vused_mem[t_addr];
		if (cmd.tupd) begin
			type_cnt_mem[ti_q] <= tc_new;
			if (new_type_q) begin
				type_keys_mem[ti_q] <= code_q;
			end
		end
		if (cmd.vupd && new_ver_q) begin
			vused_mem[ti_q] <= nv_q + VCW'(1);
		end
	end

	// version table ports
	always_ff @(posedge clk) begin
		vkey_rd <= ver_keys_mem[v_raddr];
		vcnt_rd <= ver_cnt_mem[v_raddr];
		if (cmd.vupd) begin
			ver_cnt_mem[v_waddr] <= vc_new;
			if (new_ver_q) begin
				ver_keys_mem[v_waddr] <= ver_q;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_in_use_q <= '0;
			tptr_q         <= '0;
			t_rv_q         <= 1'b0;
			vptr_q         <= '0;
			v_rv_q         <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				tptr_q <= '0;
				t_rv_q <= 1'b0;
			end else if (cmd.tscan) begin
				t_rv_q <= t_issue;
				if (t_issue) begin
					tptr_q <= tptr_q + TCW'(1);
				end
			end
			if (cmd.tupd) begin
				vptr_q <= '0;
				v_rv_q <= 1'b0;
				if (new_type_q) begin
					types_in_use_q <= types_in_use_q + TCW'(1);
				end
			end else if (cmd.vscan) begin
				v_rv_q <= v_issue;
				if (v_issue) begin
					vptr_q <= vptr_q + VCW'(1);
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= type_code;
			ver_q  <= version;
			stat_q <= STAT_OK;
		end
		if (cmd.tscan) begin
			t_ridx_q <= t_addr;
			if (sts.t_hit) begin
				ti_q       <= t_ridx_q;
				tcount_q   <= tcnt_rd;
				nv_q       <= vused_rd;
				new_type_q <= 1'b0;
			end else if (sts.t_miss) begin
				if (sts.t_full) begin
					stat_q <= STAT_TYPE_FULL;
				end else begin
					ti_q       <= types_in_use_q[IW-1:0];
					tcount_q   <= '0;
					nv_q       <= '0;
					new_type_q <= 1'b1;
				end
			end
		end
		if (cmd.tupd) begin
			tot_q   <= tc_new;
			vbase_q <= base_prod[VAW-1:0];
		end
		if (cmd.vscan) begin
			v_ridx_q <= vptr_q[VIW-1:0];
			if (sts.v_hit) begin
				vi_q      <= v_ridx_q;
				vcount_q  <= vcnt_rd;
				new_ver_q <= 1'b0;
			end else if (sts.v_miss) begin
				if (sts.v_full) begin
					stat_q <= STAT_VER_FULL;
				end else begin
					vi_q      <= nv_q[VIW-1:0];
					vcount_q  <= '0;
					new_ver_q <= 1'b1;
				end
			end
		end
		if (cmd.vupd) begin
			vtot_q <= vc_new;
		end
		if (cmd.out_load) begin
			o_stat_q  <= stat_q;
			o_ttot_q  <= (stat_q == STAT_TYPE_FULL) ? '0 : tot_q;
			o_ntype_q <= (stat_q == STAT_TYPE_FULL) ? 1'b0 : new_type_q;
			o_vtot_q  <= (stat_q == STAT_OK) ? vtot_q : '0;
			o_nver_q  <= (stat_q == STAT_OK) ? new_ver_q : 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, o_nver_q, o_ntype_q, o_vtot_q, o_ttot_q, o_stat_q};

endmodule

// ----- src/two_level_key_histogram.sv -----
// two-level key histogram: per-type counts with a per-type version sub-table
//
// input stream s_*: one transfer carries a type code and a version to count.
// output stream m_*: one transfer per input with status, the updated type and
// type-version counts, and new-type / new-version flags.
// the type table is scanned one entry per cycle, then the version row of that
// type one entry per cycle.
// one item is in flight at a time; s_tready is high only while idle and rises
// together with m_tvalid, so the next transfer is taken at the earliest while
// that result is offered.
// a finished result sits in the output register, so the next item is taken
// while m_tready is low; that item stalls at its end until the result goes.
// a full type table leaves all tables untouched; a full version row still
// counts the type. counts saturate at all ones.
// arst_n empties both tables at once (fill counts cleared), no clearing pass.
module two_level_key_histogram #(
	parameter int MAX_TYPES    = tkh_pkg::TKH_MAX_TYPES,
	parameter int MAX_VERSIONS = tkh_pkg::TKH_MAX_VERSIONS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tkh_pkg::TKH_IN_W-1:0]  s_tdata,  // type_code[31:0], version[63:32]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tkh_pkg::TKH_OUT_W-1:0] m_tdata   // status[1:0], type_total[33:2],
	                                                // version_total[65:34], new_type[66],
	                                                // new_version[67], zero[71:68]
);
	import tkh_pkg::*;

	tkh_cmd_t             cmd;
	tkh_sts_t             sts;
	logic [TKH_KEY_W-1:0] type_code, version;

	assign type_code = s_tdata[TKH_KEY_W-1:0];
	assign version   = s_tdata[2*TKH_KEY_W-1:TKH_KEY_W];

	tkh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tkh_dp #(
		.MAX_TYPES    (MAX_TYPES),
		.MAX_VERSIONS (MAX_VERSIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.type_code (type_code),
		.version   (version),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- src/tkh_checker.sv -----
// port-level checks for the two-level key histogram, bound to the top level
`include "two_level_key_histogram_defines.svh"

module tkh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tkh_pkg::TKH_OUT_W-1:0] m_tdata
);
	import tkh_pkg::*;

	`TKH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`TKH_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
	`TKH_ASSERT_IMP(a_status_code, m_tvalid, (m_tdata[1:0] == STAT_OK || m_tdata[1:0] == STAT_TYPE_FULL || m_tdata[1:0] == STAT_VER_FULL) && m_tdata[71:68] == 4'd0, "bad status code or pad bits")
	`TKH_ASSERT_IMP(a_type_full_zero, m_tvalid && m_tdata[1:0] == STAT_TYPE_FULL, m_tdata[67:2] == '0, "type-full result carries counts")
	`TKH_ASSERT_IMP(a_new_type_first, m_tvalid && m_tdata[66], m_tdata[33:2] == 32'd1 && (m_tdata[67] || m_tdata[1:0] == STAT_VER_FULL), "new type without a first count")

endmodule

bind two_level_key_histogram tkh_checker u_tkh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/tb_two_level_key_histogram.sv -----
// testbench for two_level_key_histogram: directed rows, then random traffic checked against a predictor
module tb_two_level_key_histogram;
	import tkh_pkg::*;

	localparam int NUM_TYPES    = TKH_MAX_TYPES;
	localparam int NUM_VERSIONS = TKH_MAX_VERSIONS;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_EVERY  = 250;
	localparam int TAIL_CYCLES  = 100;
	// worst quiet stretch is about one full scan plus a receiver stall plus a sender gap
	localparam int IDLE_LIMIT   = 2000;

	typedef struct packed {
		tkh_stat_t           status;
		logic [TKH_CNT_W-1:0] type_total;
		logic [TKH_CNT_W-1:0] version_total;
		logic                new_type;
		logic                new_version;
	} hist_result_t;

	typedef struct {
		logic [TKH_KEY_W-1:0] code;
		logic [TKH_KEY_W-1:0] ver;
		bit                   typed;
		hist_result_t         res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TKH_IN_W-1:0]  s_tdata;   // type_code[31:0], version[63:32]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TKH_OUT_W-1:0] m_tdata;   // status[1:0], type_total[33:2], version_total[65:34],
	                                 // new_type[66], new_version[67], zero[71:68]

	// predictor state
	int                   types_held;
	logic [TKH_KEY_W-1:0] type_keys [NUM_TYPES];
	logic [TKH_CNT_W-1:0] type_cnts [NUM_TYPES];
	int                   ver_fill  [NUM_TYPES];
	logic [TKH_KEY_W-1:0] ver_keys  [NUM_TYPES][NUM_VERSIONS];
	logic [TKH_CNT_W-1:0] ver_cnts  [NUM_TYPES][NUM_VERSIONS];

	hist_result_t pending_tallies[$];
	hist_result_t oldest;
	int           errors;
	int           items_sent;
	int           results_seen;
	int           n_counted;
	int           n_type_full;
	int           n_ver_full;
	int           burst_left;
	stim_row_t    dir_rows[18];

	two_level_key_histogram uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	// counts one item into the model tables and returns the result it should produce
	function automatic hist_result_t tally_item(input logic [TKH_KEY_W-1:0] code,
			input logic [TKH_KEY_W-1:0] ver);
		hist_result_t res;
		int           t;
		int           v;
		bit           hit;
		res = '0;
		res.status = STAT_OK;
		hit = 1'b0;
		t = 0;
		for (int i = 0; i < types_held; i++)
			if (!hit && type_keys[i] == code) begin
				hit = 1'b1;
				t = i;
			end
		if (!hit) begin
			if (types_held >= NUM_TYPES) begin
				res.status = STAT_TYPE_FULL;
				return res;
			end
			t = types_held;
			type_keys[t] = code;
			type_cnts[t] = '0;
			ver_fill[t] = 0;
			types_held++;
			res.new_type = 1'b1;
		end
		if (type_cnts[t] != '1)
			type_cnts[t] = type_cnts[t] + 1'b1;
		res.type_total = type_cnts[t];
		hit = 1'b0;
		v = 0;
		for (int i = 0; i < ver_fill[t]; i++)
			if (!hit && ver_keys[t][i] == ver) begin
				hit = 1'b1;
				v = i;
			end
		if (!hit) begin
			// type stays counted even though the version is dropped
			if (ver_fill[t] >= NUM_VERSIONS) begin
				res.status = STAT_VER_FULL;
				return res;
			end
			v = ver_fill[t];
			ver_keys[t][v] = ver;
			ver_cnts[t][v] = '0;
			ver_fill[t]++;
			res.new_version = 1'b1;
		end
		if (ver_cnts[t][v] != '1)
			ver_cnts[t][v] = ver_cnts[t][v] + 1'b1;
		res.version_total = ver_cnts[t][v];
		return res;
	endfunction

	function automatic stim_row_t exp_row(input logic [31:0] code, input logic [31:0] ver,
			input tkh_stat_t st, input logic [31:0] tt, input logic [31:0] vt,
			input logic nt, input logic nv);
		stim_row_t r;
		r.code = code;
		r.ver = ver;
		r.typed = 1'b1;
		r.res = '{status: st, type_total: tt, version_total: vt, new_type: nt,
			new_version: nv};
		return r;
	endfunction

	function automatic stim_row_t pred_row(input logic [31:0] code, input logic [31:0] ver);
		stim_row_t r;
		r.code = code;
		r.ver = ver;
		r.typed = 1'b0;
		r.res = '0;
		return r;
	endfunction

	task automatic send_item(input stim_row_t row);
		hist_result_t r;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {row.ver, row.code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = tally_item(row.code, row.ver);
		pending_tallies.push_back(row.typed ? row.res : r);
		items_sent++;
	endtask

	// burst / gap pacing on the input side
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
			burst_left = $urandom_range(1, 12);
		end
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_stimulus();
		stim_row_t row;
		int        ti;
		int        pick;
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i]);
			pace_sender();
		end
		drain_results();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			row = pred_row('0, '0);
			pick = $urandom_range(0, 99);
			ti = -1;
			if (types_held == 0 || pick < 25) begin
				if ($urandom_range(0, 1))
					row.code = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
						8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
				else
					row.code = $urandom;
			end else begin
				ti = $urandom_range(0, types_held - 1);
				row.code = type_keys[ti];
			end
			pick = $urandom_range(0, 99);
			if (ti >= 0 && ver_fill[ti] > 0 && pick < 60)
				row.ver = ver_keys[ti][$urandom_range(0, ver_fill[ti] - 1)];
			else if (pick < 80)
				row.ver = $urandom_range(0, 15);
			else
				row.ver = $urandom;
			send_item(row);
			pace_sender();
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
				drain_results();
		end
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic watch_idle();
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results pending",
			IDLE_LIMIT, pending_tallies.size());
		errors++;
	endtask

	// receiver: random stalls, with a stall-free stretch every third window
	initial begin
		int cyc;
		int stall_left;
		cyc = 0;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if ((cyc / 600) % 3 == 2) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_tallies.size() == 0) begin
				report_mismatch("unexpected result transfer", m_tdata[33:2], '0);
			end else begin
				oldest = pending_tallies.pop_front();
				case (oldest.status)
					STAT_OK:        n_counted++;
					STAT_TYPE_FULL: n_type_full++;
					default:        n_ver_full++;
				endcase
				if (m_tdata[1:0] != oldest.status)
					report_mismatch("status", 32'(m_tdata[1:0]), 32'(oldest.status));
				if (m_tdata[33:2] != oldest.type_total)
					report_mismatch("type_total", m_tdata[33:2], oldest.type_total);
				if (m_tdata[65:34] != oldest.version_total)
					report_mismatch("version_total", m_tdata[65:34], oldest.version_total);
				if (m_tdata[66] != oldest.new_type)
					report_mismatch("new_type", 32'(m_tdata[66]), 32'(oldest.new_type));
				if (m_tdata[67] != oldest.new_version)
					report_mismatch("new_version", 32'(m_tdata[67]), 32'(oldest.new_version));
				if (m_tdata[71:68] != '0)
					report_mismatch("pad bits", 32'(m_tdata[71:68]), '0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		n_counted = 0;
		n_type_full = 0;
		n_ver_full = 0;
		burst_left = 0;
		types_held = 0;
		dir_rows = '{
			exp_row(32'h0000_0000, 32'h0000_0000, STAT_OK, 1, 1, 1'b1, 1'b1),
			exp_row(32'h0000_0000, 32'h0000_0000, STAT_OK, 2, 2, 1'b0, 1'b0),
			exp_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, STAT_OK, 1, 1, 1'b1, 1'b1),
			exp_row(32'hFFFF_FFFF, 32'h0000_0000, STAT_OK, 2, 1, 1'b0, 1'b1),
			exp_row(32'h4142_4344, 32'h0000_0001, STAT_OK, 1, 1, 1'b1, 1'b1),
			pred_row(32'h4142_4344, 32'h0000_0002),
			pred_row(32'h4142_4344, 32'h0000_0003),
			pred_row(32'h4142_4344, 32'h0000_0004),
			pred_row(32'h4142_4344, 32'h0000_0005),
			pred_row(32'h4142_4344, 32'h0000_0006),
			pred_row(32'h4142_4344, 32'h0000_0007),
			pred_row(32'h4142_4344, 32'h0000_0008),
			// version row now full: type still counts, version dropped
			exp_row(32'h4142_4344, 32'h0000_0009, STAT_VER_FULL, 9, 0, 1'b0, 1'b0),
			pred_row(32'h4142_4344, 32'h0000_0005),
			exp_row(32'h4142_4344, 32'hFFFF_FFFF, STAT_VER_FULL, 11, 0, 1'b0, 1'b0),
			pred_row(32'h8000_0000, 32'h8000_0000),
			pred_row(32'h7FFF_FFFF, 32'h5555_5555),
			pred_row(32'h0000_0000, 32'hAAAA_AAAA)
		};
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		fork
			run_stimulus();
			watch_idle();
		join_any
		disable fork;
		$display("sent %0d items, checked %0d results, %0d types held at the end",
			items_sent, results_seen, types_held);
		$display("outcomes: %0d counted, %0d type table full, %0d version row full",
			n_counted, n_type_full, n_ver_full);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/tkh_pkg.sv
src/tkh_ctrl.sv
src/tkh_dp.sv
src/two_level_key_histogram.sv
src/tkh_checker.sv
verif/tb_two_level_key_histogram.sv
